/* design/dtf_pkg.sv */
// Shared types, constants and tables for the decimal text to fixed-point converter.
package dtf_pkg;

   localparam int CHAR_W          = 8;
   localparam int VALUE_W         = 48;
   localparam int RADIX           = 10;

   localparam int INT_BITS_DEF        = 23;
   localparam int FRAC_BITS_DEF       = 24;
   localparam int MAX_FRAC_DIGITS_DEF = 8;

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

   localparam logic [VALUE_W-2:0] MAG_MAX = '1;

   typedef struct packed {
      logic [CHAR_W-1:0] character;
      logic              last;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      overflow;
      logic                      malformed;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MERGE,
      ST_EMIT
   } state_type;

   function automatic logic [29:0] pow10_fn(input logic [3:0] k);
      logic [29:0] p;
      case (k)
         4'd0:    p = 30'd1;
         4'd1:    p = 30'd10;
         4'd2:    p = 30'd100;
         4'd3:    p = 30'd1000;
         4'd4:    p = 30'd10000;
         4'd5:    p = 30'd100000;
         4'd6:    p = 30'd1000000;
         4'd7:    p = 30'd10000000;
         4'd8:    p = 30'd100000000;
         4'd9:    p = 30'd1000000000;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

endpackage

/* design/dtf_frac_div.sv */
// Restoring divider that turns the decimal fraction into binary fraction bits, one per cycle.
module dtf_frac_div #(
   parameter int FRAC_BITS = dtf_pkg::FRAC_BITS_DEF,
   parameter int ACC_W     = 27
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [ACC_W-1:0]     numer,
   input  logic [ACC_W-1:0]     denom,
   output logic                 busy,
   output logic [FRAC_BITS-1:0] quotient
);

   localparam int STEP_W = $clog2(FRAC_BITS + 1);

   logic [STEP_W-1:0]    steps_ff, steps_in;
   logic [ACC_W-1:0]     rem_ff, rem_in;
   logic [ACC_W-1:0]     den_ff, den_in;
   logic [FRAC_BITS-1:0] quot_ff, quot_in;

   logic [ACC_W:0] rem_shift;
   logic [ACC_W:0] rem_diff;
   logic           fits;

   assign rem_shift = {rem_ff, 1'b0};
   assign rem_diff  = rem_shift - {1'b0, den_ff};
   assign fits      = rem_shift >= {1'b0, den_ff};

   always_comb begin
      steps_in = steps_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;
      if (start) begin
         steps_in = STEP_W'(FRAC_BITS);
         rem_in   = numer;
         den_in   = denom;
         quot_in  = '0;
      end else if (steps_ff != '0) begin
         steps_in = steps_ff - STEP_W'(1);
         rem_in   = fits ? rem_diff[ACC_W-1:0] : rem_shift[ACC_W-1:0];
         quot_in  = {quot_ff[FRAC_BITS-2:0], fits};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
      end else begin
         steps_ff <= steps_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign busy     = steps_ff != '0;
   assign quotient = quot_ff;

endmodule

/* design/decimal_text_to_fixed_point.sv */
// Top level: parses decimal text one character per request and emits a signed fixed-point value.
// A character that is not last is taken with no stall; the next can follow in the next cycle.
// A last character starts a bit-serial divide for the FRAC_BITS fraction bits, then the merge
// and emit states follow; req_stall stays high until rsp_valid rises.
// The result register frees the input side while a result waits on rsp_stall.
// Synchronous reset clears the parser state, the sequencer and the result valid.
module decimal_text_to_fixed_point #(
   parameter int INT_BITS        = dtf_pkg::INT_BITS_DEF,
   parameter int FRAC_BITS       = dtf_pkg::FRAC_BITS_DEF,
   parameter int MAX_FRAC_DIGITS = dtf_pkg::MAX_FRAC_DIGITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  dtf_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output dtf_pkg::rsp_type rsp_payload
);

   localparam int ACC_W     = $clog2(dtf_pkg::pow10_fn(4'(MAX_FRAC_DIGITS)));
   localparam int CNT_W     = $clog2(MAX_FRAC_DIGITS + 1);
   localparam int INT_EXT_W = INT_BITS + 4;
   localparam int SUM_W     = INT_BITS + FRAC_BITS + 1;
   localparam int CMP_W     = (SUM_W > dtf_pkg::VALUE_W) ? SUM_W : dtf_pkg::VALUE_W;
   localparam int MAG_W     = dtf_pkg::VALUE_W - 1;

   dtf_pkg::state_type state_ff, state_in;

   logic                at_start_ff, at_start_in;
   logic                negative_ff, negative_in;
   logic                after_point_ff, after_point_in;
   logic [INT_BITS-1:0] integer_acc_ff, integer_acc_in;
   logic [ACC_W-1:0]    fraction_acc_ff, fraction_acc_in;
   logic [CNT_W-1:0]    fraction_count_ff, fraction_count_in;
   logic                overflow_seen_ff, overflow_seen_in;
   logic                bad_seen_ff, bad_seen_in;

   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic                mag_ovf_ff, mag_ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   dtf_pkg::rsp_type    rsp_payload_ff, rsp_payload_in;

   logic                 req_fire;
   logic                 div_start;
   logic                 div_busy;
   logic [FRAC_BITS-1:0] div_quot;
   logic                 do_merge;
   logic                 do_emit;
   logic                 emit_ready;

   logic                 is_digit;
   logic [3:0]           digit;
   logic [INT_EXT_W-1:0] int_next;
   logic [ACC_W-1:0]     frac_next;
   logic [CMP_W-1:0]     mag_sum;
   logic                 mag_over;
   logic [MAG_W:0]       mag_ext;

   assign req_fire   = req_valid && !req_stall;
   assign emit_ready = !rsp_valid_ff || !rsp_stall;

   assign is_digit  = (req_payload.character >= dtf_pkg::CHAR_ZERO) &&
                      (req_payload.character <= dtf_pkg::CHAR_NINE);
   assign digit     = 4'(req_payload.character - dtf_pkg::CHAR_ZERO);
   assign int_next  = INT_EXT_W'(integer_acc_ff) * INT_EXT_W'(dtf_pkg::RADIX) +
                      INT_EXT_W'(digit);
   assign frac_next = ACC_W'(fraction_acc_ff * ACC_W'(dtf_pkg::RADIX)) + ACC_W'(digit);

   // parser
   always_comb begin
      at_start_in       = at_start_ff;
      negative_in       = negative_ff;
      after_point_in    = after_point_ff;
      integer_acc_in    = integer_acc_ff;
      fraction_acc_in   = fraction_acc_ff;
      fraction_count_in = fraction_count_ff;
      overflow_seen_in  = overflow_seen_ff;
      bad_seen_in       = bad_seen_ff;
      if (req_fire) begin
         at_start_in = 1'b0;
         if (req_payload.character == dtf_pkg::CHAR_MINUS) begin
            if (at_start_ff) begin
               negative_in = 1'b1;
            end else begin
               bad_seen_in = 1'b1;
            end
         end else if (req_payload.character == dtf_pkg::CHAR_POINT) begin
            if (after_point_ff) begin
               bad_seen_in = 1'b1;
            end else begin
               after_point_in = 1'b1;
            end
         end else if (is_digit) begin
            if (!after_point_ff) begin
               if (int_next > INT_EXT_W'({INT_BITS{1'b1}})) begin
                  integer_acc_in   = '1;
                  overflow_seen_in = 1'b1;
               end else begin
                  integer_acc_in = int_next[INT_BITS-1:0];
               end
            end else if (fraction_count_ff < CNT_W'(MAX_FRAC_DIGITS)) begin
               fraction_acc_in   = frac_next;
               fraction_count_in = fraction_count_ff + CNT_W'(1);
            end
         end else begin
            bad_seen_in = 1'b1;
         end
      end else if (do_emit) begin
         at_start_in       = 1'b1;
         negative_in       = 1'b0;
         after_point_in    = 1'b0;
         integer_acc_in    = '0;
         fraction_acc_in   = '0;
         fraction_count_in = '0;
         overflow_seen_in  = 1'b0;
         bad_seen_in       = 1'b0;
      end
   end

   dtf_frac_div #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_W     (ACC_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (fraction_acc_in),
      .denom    (ACC_W'(dtf_pkg::pow10_fn(4'(fraction_count_in)))),
      .busy     (div_busy),
      .quotient (div_quot)
   );

   // merge integer and fraction, saturate
   assign mag_sum  = (CMP_W'(integer_acc_ff) << FRAC_BITS) + CMP_W'(div_quot);
   assign mag_over = mag_sum > CMP_W'(dtf_pkg::MAG_MAX);

   always_comb begin
      mag_in     = mag_ff;
      mag_ovf_in = mag_ovf_ff;
      if (do_merge) begin
         mag_in     = mag_over ? dtf_pkg::MAG_MAX : mag_sum[MAG_W-1:0];
         mag_ovf_in = overflow_seen_ff || mag_over;
      end
   end

   // result register
   assign mag_ext = {1'b0, mag_ff};

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      if (do_emit) begin
         rsp_valid_in             = 1'b1;
         rsp_payload_in.value     = negative_ff ? -mag_ext : mag_ext;
         rsp_payload_in.overflow  = mag_ovf_ff;
         rsp_payload_in.malformed = bad_seen_ff;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dtf_pkg::ST_IDLE: begin
            if (req_fire && req_payload.last) begin
               state_in = dtf_pkg::ST_DIVIDE;
            end
         end
         dtf_pkg::ST_DIVIDE: begin
            if (!div_busy) begin
               state_in = dtf_pkg::ST_MERGE;
            end
         end
         dtf_pkg::ST_MERGE: begin
            state_in = dtf_pkg::ST_EMIT;
         end
         dtf_pkg::ST_EMIT: begin
            if (emit_ready) begin
               state_in = dtf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dtf_pkg::ST_IDLE;
         end
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall = 1'b1;
      div_start = 1'b0;
      do_merge  = 1'b0;
      do_emit   = 1'b0;
      unique case (state_ff)
         dtf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            div_start = req_valid && req_payload.last;
         end
         dtf_pkg::ST_DIVIDE: begin
         end
         dtf_pkg::ST_MERGE: begin
            do_merge = 1'b1;
         end
         dtf_pkg::ST_EMIT: begin
            do_emit = emit_ready;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= dtf_pkg::ST_IDLE;
         at_start_ff       <= 1'b1;
         negative_ff       <= 1'b0;
         after_point_ff    <= 1'b0;
         integer_acc_ff    <= '0;
         fraction_acc_ff   <= '0;
         fraction_count_ff <= '0;
         overflow_seen_ff  <= 1'b0;
         bad_seen_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         state_ff          <= state_in;
         at_start_ff       <= at_start_in;
         negative_ff       <= negative_in;
         after_point_ff    <= after_point_in;
         integer_acc_ff    <= integer_acc_in;
         fraction_acc_ff   <= fraction_acc_in;
         fraction_count_ff <= fraction_count_in;
         overflow_seen_ff  <= overflow_seen_in;
         bad_seen_ff       <= bad_seen_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
      mag_ff         <= mag_in;
      mag_ovf_ff     <= mag_ovf_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_last_starts_divide: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_payload.last |=> state_ff == dtf_pkg::ST_DIVIDE && div_busy)
      else $error("last character did not start the divide");

   a_divide_to_merge: assert property (@(posedge clock) disable iff (reset)
      state_ff == dtf_pkg::ST_DIVIDE && !div_busy |=> state_ff == dtf_pkg::ST_MERGE)
      else $error("finished divide did not move to merge");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> state_ff == dtf_pkg::ST_IDLE && !rsp_valid_ff && at_start_ff)
      else $error("reset did not clear sequencer and result");

endmodule
